>>> design/assert_macros.svh
// Assertion macros for the timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define DTQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/dtq_pkg.sv
// Types and constants of the deadline timer queue.
package dtq_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int TIME_BITS_DEF = 32;
   localparam int LEAD_BITS     = 10;
   localparam logic [LEAD_BITS-1:0] LEAD_RESET = 10'd10;

   typedef enum logic [1:0] {
      FN_SCHED  = 2'd0,
      FN_CANCEL = 2'd1,
      FN_EXPIRE = 2'd2,
      FN_DONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KD_GRANT  = 2'd0,
      KD_FIRED  = 2'd1,
      KD_ALARM  = 2'd2,
      KD_CANACK = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FIND,
      ST_GRANT,
      ST_GRANT_ERR,
      ST_CANCEL,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_DO,
      ST_PURGE,
      ST_PUSH_RD,
      ST_PUSH_CHK,
      ST_ALARM_RD,
      ST_ALARM,
      ST_EXP_HEAD,
      ST_EXP_CHK,
      ST_DONE_CHK,
      ST_PERIOD
   } state_type;

endpackage

>>> design/dtq_ram.sv
// Generic single-port-write, registered-read RAM.
module dtq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/deadline_timer_queue.sv
// Top level of the deadline timer queue: event sequencer, slot flags, queue.
//
//  channel  dir  handshake            beat
//  req_     in   req_valid/req_stall  one timer event
//  rsp_     out  rsp_valid/rsp_stall  one result, rsp_last on the final one
//  csr_     in   csr_valid/csr_ready  min_lead_ms write
//
// An event's length is set by output stalls and by the walk of the deadline
// memory, a read state and a compare or check state per entry during sorted
// insertion and head expiry, and by the purge, one queue entry a cycle.
// Free-slot search scans one slot a cycle.
// Reset is synchronous, active high; no clearing pass is needed.
// A stalled result holds the sequencer at the state that emits it.
`include "assert_macros.svh"

module deadline_timer_queue
   import dtq_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [31:0]          req_now_ms,
   input  logic [30:0]          req_delay_ms,
   input  logic [30:0]          req_period_ms,
   input  logic [3:0]           req_slot_id,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [3:0]           rsp_slot_out,
   output logic [31:0]          rsp_alarm_time,
   output logic                 rsp_alarm_armed,
   output logic                 rsp_error,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LEAD_BITS-1:0] csr_min_lead_ms
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int TB = TIME_BITS;

   // control state
   state_type            state_ff, state_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOTS-1:0]     canc_ff, canc_in;
   logic [SLOTS-1:0]     queued_ff, queued_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_v_ff, rsp_v_in;
   logic [LEAD_BITS-1:0] lead_ff, lead_in;

   // working registers
   logic [TB-1:0]        now_ff, now_in;
   logic [TB-1:0]        new_dl_ff, new_dl_in;
   logic [30:0]          period_ff, period_in;
   logic [3:0]           sid_ff, sid_in;
   logic [SW-1:0]        idx_ff, idx_in;
   logic [SW-1:0]        cur_ff, cur_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        wri_ff, wri_in;
   logic [SW-1:0]        q_ff [SLOTS];
   logic [SW-1:0]        q_in [SLOTS];

   // result register
   logic [1:0]           kind_ff, kind_in;
   logic [3:0]           slot_ff, slot_in;
   logic [31:0]          alarm_ff, alarm_in;
   logic                 armed_ff, armed_in;
   logic                 err_ff, err_in;
   logic                 last_ff, last_in;

   // memories
   logic                 dl_we, dl_re, pr_we, pr_re;
   logic [SW-1:0]        dl_waddr, dl_raddr, pr_raddr;
   logic [TB-1:0]        dl_wdata, dl_rdata;
   logic [30:0]          pr_rdata;

   logic                 out_free;
   logic [SW-1:0]        sid_idx;
   logic                 sid_range;
   logic [SW-1:0]        head;
   logic [SW-1:0]        rd_slot;

   function automatic logic is_near(input logic [TB-1:0] d, input logic [TB-1:0] n,
                                    input logic [LEAD_BITS-1:0] lead);
      logic [TB-1:0] diff;
      diff = d - n;
      return diff[TB-1] || (diff < TB'(lead));
   endfunction

   function automatic logic is_before(input logic [TB-1:0] a, input logic [TB-1:0] b);
      logic [TB-1:0] diff;
      diff = a - b;
      return diff[TB-1];
   endfunction

   dtq_ram #(.WIDTH(TB), .DEPTH(SLOTS)) u_dl_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_wdata),
      .rd_en   (dl_re),
      .rd_addr (dl_raddr),
      .rd_data (dl_rdata)
   );

   dtq_ram #(.WIDTH(31), .DEPTH(SLOTS)) u_pr_ram (
      .clock   (clock),
      .wr_en   (pr_we),
      .wr_addr (idx_ff),
      .wr_data (period_ff),
      .rd_en   (pr_re),
      .rd_addr (pr_raddr),
      .rd_data (pr_rdata)
   );

   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign sid_idx   = SW'(sid_ff);
   assign sid_range = int'(sid_ff) < SLOTS;
   assign head      = q_ff[0];
   assign rd_slot   = q_ff[pos_ff[SW-1:0]];
   assign pr_raddr  = sid_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      canc_in   = canc_ff;
      queued_in = queued_ff;
      cnt_in    = cnt_ff;
      lead_in   = lead_ff;
      now_in    = now_ff;
      new_dl_in = new_dl_ff;
      period_in = period_ff;
      sid_in    = sid_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      wri_in    = wri_ff;
      q_in      = q_ff;
      kind_in   = kind_ff;
      slot_in   = slot_ff;
      alarm_in  = alarm_ff;
      armed_in  = armed_ff;
      err_in    = err_ff;
      last_in   = last_ff;
      rsp_v_in  = rsp_stall ? rsp_v_ff : 1'b0;
      dl_we     = 1'b0;
      dl_waddr  = cur_ff;
      dl_wdata  = new_dl_ff;
      dl_re     = 1'b0;
      dl_raddr  = head;
      pr_we     = 1'b0;
      pr_re     = 1'b0;

      if (csr_valid) begin
         lead_in = csr_min_lead_ms;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in    = TB'(req_now_ms);
               new_dl_in = TB'(req_now_ms) + TB'(req_delay_ms);
               period_in = req_period_ms;
               sid_in    = req_slot_id;
               idx_in    = '0;
               unique case (func_type'(req_func))
                  FN_SCHED:  state_in = ST_FIND;
                  FN_CANCEL: state_in = ST_CANCEL;
                  FN_EXPIRE: state_in = ST_EXP_HEAD;
                  FN_DONE:   state_in = ST_DONE_CHK;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end

         ST_FIND: begin
            if (!valid_ff[idx_ff]) begin
               valid_in[idx_ff] = 1'b1;
               canc_in[idx_ff]  = 1'b0;
               dl_we    = 1'b1;
               dl_waddr = idx_ff;
               pr_we    = 1'b1;
               cur_in   = idx_ff;
               state_in = ST_GRANT;
            end else if (idx_ff == SW'(SLOTS - 1)) begin
               state_in = ST_GRANT_ERR;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_GRANT: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               kind_in  = KD_GRANT;
               slot_in  = 4'(cur_ff);
               alarm_in = '0;
               armed_in = 1'b0;
               err_in   = 1'b0;
               last_in  = 1'b0;
               pos_in   = '0;
               state_in = ST_INS_RD;
            end
         end

         ST_GRANT_ERR: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               kind_in  = KD_GRANT;
               slot_in  = '0;
               alarm_in = '0;
               armed_in = 1'b0;
               err_in   = 1'b1;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_CANCEL: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               kind_in  = KD_CANACK;
               slot_in  = sid_ff;
               alarm_in = '0;
               armed_in = 1'b0;
               last_in  = 1'b1;
               err_in   = 1'b1;
               if (sid_range && valid_ff[sid_idx]) begin
                  canc_in[sid_idx] = 1'b1;
                  err_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end

         // walk the queue until an entry is later than the new deadline
         ST_INS_RD: begin
            if (pos_ff == cnt_ff) begin
               state_in = ST_INS_DO;
            end else begin
               dl_re    = 1'b1;
               dl_raddr = rd_slot;
               state_in = ST_INS_CMP;
            end
         end

         ST_INS_CMP: begin
            if (is_before(new_dl_ff, dl_rdata)) begin
               state_in = ST_INS_DO;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_INS_RD;
            end
         end

         ST_INS_DO: begin
            for (int i = 1; i < SLOTS; i++) begin
               if (CW'(i) > pos_ff) begin
                  q_in[i] = q_ff[i-1];
               end
            end
            q_in[pos_ff[SW-1:0]] = cur_ff;
            cnt_in           = cnt_ff + 1'b1;
            queued_in[cur_ff] = 1'b1;
            pos_in           = '0;
            wri_in           = '0;
            state_in         = ST_PURGE;
         end

         // compact the queue, dropping cancelled entries
         ST_PURGE: begin
            if (pos_ff == cnt_ff) begin
               cnt_in   = wri_ff;
               state_in = (wri_ff == '0) ? ST_ALARM_RD : ST_PUSH_RD;
            end else begin
               if (canc_ff[rd_slot]) begin
                  valid_in[rd_slot]  = 1'b0;
                  canc_in[rd_slot]   = 1'b0;
                  queued_in[rd_slot] = 1'b0;
               end else begin
                  q_in[wri_ff[SW-1:0]] = rd_slot;
                  wri_in = wri_ff + 1'b1;
               end
               pos_in = pos_ff + 1'b1;
            end
         end

         ST_PUSH_RD: begin
            dl_re    = 1'b1;
            dl_raddr = head;
            state_in = ST_PUSH_CHK;
         end

         ST_PUSH_CHK: begin
            if (is_near(dl_rdata, now_ff, lead_ff)) begin
               dl_we    = 1'b1;
               dl_waddr = head;
               dl_wdata = now_ff + TB'(lead_ff);
            end
            state_in = ST_ALARM_RD;
         end

         ST_ALARM_RD: begin
            dl_re    = (cnt_ff != '0);
            dl_raddr = head;
            state_in = ST_ALARM;
         end

         ST_ALARM: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               kind_in  = KD_ALARM;
               slot_in  = '0;
               armed_in = (cnt_ff != '0);
               alarm_in = (cnt_ff != '0) ? 32'(dl_rdata) : 32'd0;
               err_in   = 1'b0;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_EXP_HEAD: begin
            if (cnt_ff == '0) begin
               pos_in   = '0;
               wri_in   = '0;
               state_in = ST_PURGE;
            end else if (canc_ff[head]) begin
               valid_in[head]  = 1'b0;
               canc_in[head]   = 1'b0;
               queued_in[head] = 1'b0;
               for (int i = 0; i < SLOTS - 1; i++) begin
                  q_in[i] = q_ff[i+1];
               end
               cnt_in = cnt_ff - 1'b1;
            end else begin
               dl_re    = 1'b1;
               dl_raddr = head;
               state_in = ST_EXP_CHK;
            end
         end

         ST_EXP_CHK: begin
            if (!is_near(dl_rdata, now_ff, lead_ff)) begin
               pos_in   = '0;
               wri_in   = '0;
               state_in = ST_PURGE;
            end else if (out_free) begin
               rsp_v_in = 1'b1;
               kind_in  = KD_FIRED;
               slot_in  = 4'(head);
               alarm_in = '0;
               armed_in = 1'b0;
               err_in   = 1'b0;
               last_in  = 1'b0;
               queued_in[head] = 1'b0;
               for (int i = 0; i < SLOTS - 1; i++) begin
                  q_in[i] = q_ff[i+1];
               end
               cnt_in   = cnt_ff - 1'b1;
               state_in = ST_EXP_HEAD;
            end
         end

         ST_DONE_CHK: begin
            if (!sid_range || !valid_ff[sid_idx] || queued_ff[sid_idx]) begin
               state_in = ST_IDLE;
            end else if (canc_ff[sid_idx]) begin
               valid_in[sid_idx] = 1'b0;
               canc_in[sid_idx]  = 1'b0;
               state_in = ST_ALARM_RD;
            end else begin
               pr_re    = 1'b1;
               cur_in   = sid_idx;
               // re-queue a periodic timer once its period is back
               idx_in   = sid_idx;
               state_in = ST_PERIOD;
            end
         end

         ST_PERIOD: begin
            if (pr_rdata != '0) begin
               new_dl_in = now_ff + TB'(pr_rdata);
               dl_we     = 1'b1;
               dl_waddr  = cur_ff;
               dl_wdata  = now_ff + TB'(pr_rdata);
               pos_in    = '0;
               state_in  = ST_INS_RD;
            end else begin
               valid_in[cur_ff] = 1'b0;
               canc_in[cur_ff]  = 1'b0;
               state_in = ST_ALARM_RD;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         canc_ff   <= '0;
         queued_ff <= '0;
         cnt_ff    <= '0;
         rsp_v_ff  <= 1'b0;
         lead_ff   <= LEAD_RESET;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         canc_ff   <= canc_in;
         queued_ff <= queued_in;
         cnt_ff    <= cnt_in;
         rsp_v_ff  <= rsp_v_in;
         lead_ff   <= lead_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      new_dl_ff <= new_dl_in;
      period_ff <= period_in;
      sid_ff    <= sid_in;
      idx_ff    <= idx_in;
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      wri_ff    <= wri_in;
      q_ff      <= q_in;
      kind_ff   <= kind_in;
      slot_ff   <= slot_in;
      alarm_ff  <= alarm_in;
      armed_ff  <= armed_in;
      err_ff    <= err_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_slot_out    = slot_ff;
   assign rsp_alarm_time  = alarm_ff;
   assign rsp_alarm_armed = armed_ff;
   assign rsp_error       = err_ff;
   assign rsp_last        = last_ff;

   `DTQ_ASSERT_IMP(a_queued_valid, clock, reset, 1'b1, (queued_ff & ~valid_ff) == '0, "queued slot not valid")
   `DTQ_ASSERT_IMP(a_count_flags, clock, reset, state_ff == ST_IDLE, $countones(queued_ff) == int'(cnt_ff), "queue count disagrees with queued marks")
   `DTQ_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE, "accepted event left sequencer idle")

endmodule

>>> tb/deadline_timer_queue_tb.sv
// Testbench for the deadline timer queue: predicted results checked beat by beat.
`timescale 1ns / 100ps

module deadline_timer_queue_tb
   import dtq_pkg::*;
();

   localparam int NSLOT = 16;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [31:0] alarm;
      logic        armed;
      logic        err;
      logic        last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_func = FN_SCHED;
   logic [31:0] req_now_ms = '0;
   logic [30:0] req_delay_ms = '0;
   logic [30:0] req_period_ms = '0;
   logic [3:0] req_slot_id = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [3:0] rsp_slot_out;
   logic [31:0] rsp_alarm_time;
   logic rsp_alarm_armed;
   logic rsp_error;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LEAD_BITS-1:0] csr_min_lead_ms = '0;

   deadline_timer_queue uut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [9:0]  lead_ms;
   logic        tm_valid [NSLOT];
   logic        tm_cancel [NSLOT];
   logic        tm_queued [NSLOT];
   logic [31:0] tm_deadline [NSLOT];
   logic [30:0] tm_period [NSLOT];
   int          order_q [$];
   result_type  pending_results [$];

   int  failures = 0;
   int  idle_cycles = 0;
   bit  rx_jitter = 1'b1;
   bit  tx_jitter = 1'b1;
   int  hold_off = 0;
   logic [31:0] clock_ms = 32'd1000;

   function automatic bit is_near(logic [31:0] d, logic [31:0] now);
      logic [31:0] diff;
      diff = d - now;
      return diff[31] || (diff < {22'd0, lead_ms});
   endfunction

   function automatic void add_result(kind_type k, logic [3:0] s, logic [31:0] a,
                                      logic armed, logic e);
      result_type r;
      r = '{k, s, a, armed, e, 1'b0};
      pending_results = {pending_results, r};
   endfunction

   function automatic void add_alarm();
      if (order_q.size() > 0)
         add_result(KD_ALARM, 4'd0, tm_deadline[order_q[0]], 1'b1, 1'b0);
      else
         add_result(KD_ALARM, 4'd0, 32'd0, 1'b0, 1'b0);
   endfunction

   function automatic void purge_push(logic [31:0] now);
      int kept [$];
      if (order_q.size() == 0) return;
      foreach (order_q[i]) begin
         if (tm_cancel[order_q[i]]) begin
            tm_valid[order_q[i]] = 0;
            tm_cancel[order_q[i]] = 0;
            tm_queued[order_q[i]] = 0;
         end else begin
            kept = {kept, order_q[i]};
         end
      end
      order_q = kept;
      if (order_q.size() > 0 && is_near(tm_deadline[order_q[0]], now))
         tm_deadline[order_q[0]] = now + {22'd0, lead_ms};
   endfunction

   function automatic void insert_sorted(int s, logic [31:0] now);
      int pos;
      logic [31:0] diff;
      pos = 0;
      while (pos < order_q.size()) begin
         diff = tm_deadline[s] - tm_deadline[order_q[pos]];
         if (diff[31]) break;
         pos++;
      end
      order_q.insert(pos, s);
      tm_queued[s] = 1;
      purge_push(now);
   endfunction

   // Work out the result beats of one timer event.
   function automatic void predict_event(func_type f, logic [31:0] now, logic [30:0] dly,
                                         logic [30:0] per, logic [3:0] sid);
      int s, n0, h;
      n0 = pending_results.size();
      case (f)
         FN_SCHED: begin
            s = 0;
            while (s < NSLOT && tm_valid[s]) s++;
            if (s >= NSLOT) begin
               add_result(KD_GRANT, 4'd0, 32'd0, 1'b0, 1'b1);
            end else begin
               tm_valid[s] = 1;
               tm_cancel[s] = 0;
               tm_deadline[s] = now + {1'b0, dly};
               tm_period[s] = per;
               add_result(KD_GRANT, s[3:0], 32'd0, 1'b0, 1'b0);
               insert_sorted(s, now);
               add_alarm();
            end
         end
         FN_CANCEL: begin
            if (tm_valid[sid]) begin
               tm_cancel[sid] = 1;
               add_result(KD_CANACK, sid, 32'd0, 1'b0, 1'b0);
            end else begin
               add_result(KD_CANACK, sid, 32'd0, 1'b0, 1'b1);
            end
         end
         FN_EXPIRE: begin
            while (order_q.size() > 0) begin
               h = order_q[0];
               if (tm_cancel[h]) begin
                  tm_valid[h] = 0;
                  tm_cancel[h] = 0;
                  tm_queued[h] = 0;
               end else if (is_near(tm_deadline[h], now)) begin
                  tm_queued[h] = 0;
                  add_result(KD_FIRED, h[3:0], 32'd0, 1'b0, 1'b0);
               end else begin
                  break;
               end
               order_q.delete(0);
            end
            purge_push(now);
            add_alarm();
         end
         default: begin
            if (!tm_valid[sid] || tm_queued[sid]) return;
            if (!tm_cancel[sid] && tm_period[sid] != 0) begin
               tm_deadline[sid] = now + {1'b0, tm_period[sid]};
               insert_sorted(sid, now);
            end else begin
               tm_valid[sid] = 0;
               tm_cancel[sid] = 0;
               tm_queued[sid] = 0;
            end
            add_alarm();
         end
      endcase
      if (pending_results.size() > n0)
         pending_results[pending_results.size()-1].last = 1'b1;
   endfunction

   // Send one event beat; the prediction runs on acceptance.
   task automatic send_event(func_type f, logic [31:0] now, logic [30:0] dly,
                             logic [30:0] per, logic [3:0] sid);
      int gap;
      if (tx_jitter && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_now_ms <= now;
      req_delay_ms <= dly;
      req_period_ms <= per;
      req_slot_id <= sid;
      do @(posedge clock); while (req_stall);
      predict_event(f, now, dly, per, sid);
      req_valid <= 1'b0;
      // the block is busy for at least this cycle after an accept
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() > 0) @(posedge clock);
      repeat (4 * NSLOT + 20) @(posedge clock);
   endtask

   task automatic write_lead(logic [9:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_min_lead_ms <= v;
      do @(posedge clock); while (!csr_ready);
      lead_ms = v;
      csr_valid <= 1'b0;
   endtask

   // Pick a handle that is running, so done takes effect most of the time.
   function automatic logic [3:0] running_slot();
      int c [$];
      for (int i = 0; i < NSLOT; i++)
         if (tm_valid[i] && !tm_queued[i]) c = {c, i};
      if (c.size() == 0 || $urandom_range(0, 4) == 0) return 4'($urandom_range(0, 15));
      return 4'(c[$urandom_range(0, c.size() - 1)]);
   endfunction

   task automatic send_random();
      logic [30:0] dly, per;
      logic [31:0] step;
      int pick;
      step = $urandom_range(0, 40);
      if ($urandom_range(0, 30) == 0) step = $urandom;
      clock_ms = clock_ms + step;
      dly = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 200));
      per = ($urandom_range(0, 2) == 0) ? 31'd0 :
            ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(1, 150));
      pick = $urandom_range(0, 9);
      if (pick < 3) send_event(FN_SCHED, clock_ms, dly, per, 4'($urandom));
      else if (pick < 4) send_event(FN_CANCEL, clock_ms, dly, per, 4'($urandom));
      else if (pick < 7) send_event(FN_EXPIRE, clock_ms, dly, per, 4'($urandom));
      else send_event(FN_DONE, clock_ms, dly, per, running_slot());
   endtask

   task automatic test_directed();
      send_event(FN_EXPIRE, 32'd0, 31'd0, 31'd0, 4'd0);
      send_event(FN_CANCEL, 32'd0, 31'd0, 31'd0, 4'd15);
      send_event(FN_DONE, 32'd0, 31'd0, 31'd0, 4'd3);
      send_event(FN_SCHED, 32'hFFFF_FFF0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 4'd0);
      send_event(FN_SCHED, 32'hFFFF_FFF0, 31'd100, 31'd0, 4'd0);
      send_event(FN_SCHED, 32'hFFFF_FFF0, 31'd100, 31'd50, 4'd0);
      send_event(FN_SCHED, 32'hFFFF_FFF0, 31'd0, 31'd5, 4'd0);
      send_event(FN_CANCEL, 32'hFFFF_FFF0, 31'd0, 31'd0, 4'd1);
      send_event(FN_DONE, 32'hFFFF_FFF0, 31'd0, 31'd0, 4'd2);
      send_event(FN_EXPIRE, 32'h0000_0080, 31'd0, 31'd0, 4'd0);
      send_event(FN_DONE, 32'h0000_0090, 31'd0, 31'd0, 4'd3);
      send_event(FN_DONE, 32'h0000_0090, 31'd0, 31'd0, 4'd2);
      send_event(FN_CANCEL, 32'h0000_0090, 31'd0, 31'd0, 4'd0);
      send_event(FN_EXPIRE, 32'h8000_0000, 31'd0, 31'd0, 4'd0);
      // schedule more timers than there are slots: the free ones fill, the rest are refused
      for (int i = 0; i < NSLOT + 1; i++)
         send_event(FN_SCHED, 32'd500, 31'($urandom_range(0, 30)), 31'd0, 4'd0);
   endtask

   task automatic test_lead_extremes();
      write_lead(10'd0);
      send_event(FN_EXPIRE, 32'hFFFF_FFFF, 31'd0, 31'd0, 4'd0);
      for (int i = 0; i < NSLOT; i++) send_event(FN_CANCEL, 32'd0, 31'd0, 31'd0, i[3:0]);
      send_event(FN_EXPIRE, 32'd10, 31'd0, 31'd0, 4'd0);
      write_lead(10'd1000);
      send_event(FN_SCHED, 32'd20, 31'd999, 31'd3, 4'd0);
      send_event(FN_SCHED, 32'd20, 31'd1000, 31'd0, 4'd0);
      send_event(FN_EXPIRE, 32'd21, 31'd0, 31'd0, 4'd0);
      write_lead(10'h3FF);
      write_lead(10'd10);
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 300;
            while (hold_off > 0) begin
               @(posedge clock);
               hold_off--;
            end
         end
         for (int i = 0; i < 30; i++) send_random();
      join
      wait_drained();
   endtask

   task automatic test_random();
      for (int i = 0; i < 100; i++) begin
         if (i % 40 == 39) write_lead(10'($urandom_range(0, 1000)));
         if (i == 70) begin
            rx_jitter = 0;
            tx_jitter = 0;
         end
         send_random();
      end
   endtask

   // Receiver stall: random bursts, or a long hold-off.
   always @(posedge clock) begin
      if (hold_off > 0) rsp_stall <= 1'b1;
      else if (!rx_jitter) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 3) != 0);
      else rsp_stall <= ($urandom_range(0, 5) == 0);
   end

   // Compare each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d slot %0d", $time, rsp_kind, rsp_slot_out);
            failures++;
         end else begin
            exp_r = pending_results[0];
            pending_results.delete(0);
            if ({rsp_kind, rsp_slot_out, rsp_alarm_time, rsp_alarm_armed, rsp_error,
                 rsp_last} !== exp_r) begin
               $display("%0t: mismatch expected kind %0d slot %0d alarm %h armed %b err %b last %b",
                        $time, exp_r.kind, exp_r.slot, exp_r.alarm, exp_r.armed, exp_r.err,
                        exp_r.last);
               $display("%0t:          actual kind %0d slot %0d alarm %h armed %b err %b last %b",
                        $time, rsp_kind, rsp_slot_out, rsp_alarm_time, rsp_alarm_armed,
                        rsp_error, rsp_last);
               failures++;
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      lead_ms = LEAD_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         tm_valid[i] = 0;
         tm_cancel[i] = 0;
         tm_queued[i] = 0;
         tm_deadline[i] = 0;
         tm_period[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_lead_extremes();
      test_backpressure();
      wait_drained();
      test_random();
      wait_drained();
      if (failures == 0 && pending_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
